FILE: hdl/gbfs_pkg.sv
// Package with the shared constants, codes and types of the breadth-first search engine.
package gbfs_pkg;

    localparam int NUM_VERTICES = 32;
    localparam int MAX_DEGREE   = 16;
    localparam int VW  = 5;                              // vertex field width
    localparam int NVW = $clog2(NUM_VERTICES);           // vertex index width
    localparam int DGW = $clog2(MAX_DEGREE + 1);         // degree count width
    localparam int SLW = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
    localparam int ADW = $clog2(NUM_VERTICES * MAX_DEGREE);
    localparam int QCW = $clog2(NUM_VERTICES + 1);       // queue pointer width

    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_BFS   = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;
    localparam logic [1:0] OP_RSVD  = 2'd3;

    localparam logic KIND_ACK    = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    typedef struct packed {
        logic          kind;
        logic [VW-1:0] vertex;
        logic          status;
        logic          last;
    } result_t;

endpackage

FILE: hdl/gbfs_ram.sv
// Generic single-port-write, one-read synchronous RAM with registered read.
module gbfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

FILE: hdl/graph_bfs_engine.sv
// Top level of the breadth-first search engine over bounded adjacency lists.
//
// Input words arrive on s_axis: tuser = opcode, tdata = {vertex_a, vertex_b} from the
// low bit up. Add edge (opcode 0) appends each endpoint to the other's list and answers
// with one acknowledgement word, status 1 when a list is full or an endpoint is out
// of range. Clear (opcode 2) empties all lists and answers with one acknowledgement.
// Traversal (opcode 1) emits the visited vertices in queue order, tlast on the last.
// Opcode 3 is dropped without a result.
// Results leave on m_axis: tdata = {vertex, status} from the low bit up, tuser =
// kind, tlast = last. A result register holds a word until the receiver takes it;
// while it is stalled the sequencer waits, nothing is lost.
// An add edge reads both degrees, checks them and, when it is accepted, writes the
// two list entries before its acknowledgement. A traversal reads the queue memory
// and then the adjacency memory, both with registered reads; a vertex is reported
// once its list has been scanned. s_axis_tready is high only while the sequencer
// is idle, so one word is in flight at a time and the next is taken the cycle after
// the last result of the previous word has moved into the result register.
// Reset clears the degree valid bits, the visited map, the sequencer and the output
// register.
module graph_bfs_engine (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // vertex_a[4:0], vertex_b[9:5]
    input  logic [1:0]  s_axis_tuser,   // opcode[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // vertex[4:0], status[5]
    output logic        m_axis_tuser,   // kind
    output logic        m_axis_tlast
);
    gbfs_pkg::result_t res;
    logic              res_valid;
    logic              res_ready;

    gbfs_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_op     (s_axis_tuser),
        .in_a      (s_axis_tdata[4:0]),
        .in_b      (s_axis_tdata[9:5]),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    gbfs_outreg u_out (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .res_valid     (res_valid),
        .res_ready     (res_ready),
        .res           (res),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );
endmodule

FILE: hdl/gbfs_outreg.sv
// Output register of the result stream.
module gbfs_outreg (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              res_valid,
    output logic              res_ready,
    input  gbfs_pkg::result_t res,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [7:0]        m_axis_tdata,
    output logic              m_axis_tuser,
    output logic              m_axis_tlast
);
    logic              valid_reg;
    gbfs_pkg::result_t data_reg;

    assign res_ready = !valid_reg || m_axis_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (res_ready) begin
            valid_reg <= res_valid;
        end
        if (res_ready && res_valid) begin
            data_reg <= res;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = {2'b00, data_reg.status, data_reg.vertex};
    assign m_axis_tuser  = data_reg.kind;
    assign m_axis_tlast  = data_reg.last;
endmodule

FILE: hdl/gbfs_core.sv
// Sequencer that updates the graph memories and walks the traversal queue.
module gbfs_core (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [1:0]                 in_op,
    input  logic [gbfs_pkg::VW-1:0]    in_a,
    input  logic [gbfs_pkg::VW-1:0]    in_b,
    output logic                       res_valid,
    input  logic                       res_ready,
    output gbfs_pkg::result_t          res
);
    localparam int NV  = gbfs_pkg::NUM_VERTICES;
    localparam int NVW = gbfs_pkg::NVW;
    localparam int DGW = gbfs_pkg::DGW;
    localparam int SLW = gbfs_pkg::SLW;
    localparam int ADW = gbfs_pkg::ADW;
    localparam int QCW = gbfs_pkg::QCW;
    localparam int VW  = gbfs_pkg::VW;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_AREAD = 10'b0000000010,   // degrees of a and b captured
        S_ACHK  = 10'b0000000100,
        S_AWR2  = 10'b0000001000,
        S_EMIT  = 10'b0000010000,   // one result waits for the output side
        S_QRD   = 10'b0000100000,   // queue read issued
        S_QGOT  = 10'b0001000000,   // vertex popped
        S_LRD   = 10'b0010000000,   // adjacency read issued
        S_LGOT  = 10'b0100000000,
        S_VWAIT = 10'b1000000000    // report waits for the output side
    } state_t;

    state_t state_reg, state_next;

    // Degrees live in flip-flops with one valid bit each, so clear only resets the valid bits.
    logic [DGW-1:0] deg_reg [NV];
    logic [NV-1:0]  degv_reg;
    logic [NV-1:0]  vis_reg;

    logic [VW-1:0]  a_reg, b_reg;
    logic [DGW-1:0] da_reg, db_reg;
    gbfs_pkg::result_t out_reg;
    logic [QCW-1:0] head_reg, tail_reg;
    logic [NVW-1:0] cur_reg;
    logic [DGW-1:0] cdeg_reg, idx_reg;

    // adjacency memory
    logic           adj_we;
    logic [ADW-1:0] adj_waddr, adj_raddr;
    logic [VW-1:0]  adj_wdata, adj_rdata;
    // queue memory
    logic           q_we;
    logic [NVW-1:0] q_waddr, q_raddr;
    logic [VW-1:0]  q_wdata, q_rdata;

    gbfs_ram #(.WIDTH(VW), .DEPTH(NV * gbfs_pkg::MAX_DEGREE)) u_adj (
        .aclk(aclk), .we(adj_we), .waddr(adj_waddr), .wdata(adj_wdata),
        .raddr(adj_raddr), .rdata(adj_rdata)
    );
    gbfs_ram #(.WIDTH(VW), .DEPTH(NV)) u_q (
        .aclk(aclk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
        .raddr(q_raddr), .rdata(q_rdata)
    );

    function automatic logic in_range(input logic [VW-1:0] v);
        in_range = ({1'b0, v} < (VW + 1)'(NV));
    endfunction

    function automatic logic [DGW-1:0] deg_of(input logic [VW-1:0] v,
                                              input logic [NV-1:0] dv,
                                              input logic [DGW-1:0] d);
        deg_of = dv[v[NVW-1:0]] ? d : '0;
    endfunction

    logic [DGW-1:0] deg_a, deg_b, deg_q;
    assign deg_a = deg_of(a_reg, degv_reg, deg_reg[a_reg[NVW-1:0]]);
    assign deg_b = deg_of(b_reg, degv_reg, deg_reg[b_reg[NVW-1:0]]);
    assign deg_q = deg_of(q_rdata, degv_reg, deg_reg[q_rdata[NVW-1:0]]);

    logic [DGW:0] need_a, need_b;
    logic         w_ok, fresh;
    always_comb begin
        need_a = {1'b0, da_reg} + ((a_reg == b_reg) ? (DGW + 1)'(2) : (DGW + 1)'(1));
        need_b = {1'b0, db_reg} + (DGW + 1)'(1);
        w_ok = in_range(a_reg) && in_range(b_reg) &&
               (need_a <= (DGW + 1)'(gbfs_pkg::MAX_DEGREE)) &&
               ((a_reg == b_reg) || (need_b <= (DGW + 1)'(gbfs_pkg::MAX_DEGREE)));
        fresh = in_range(adj_rdata) && !vis_reg[adj_rdata[NVW-1:0]] &&
                (tail_reg < QCW'(NV));
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_EMIT) || (state_reg == S_VWAIT);
    assign res       = out_reg;

    always_comb begin
        state_next = state_reg;
        adj_we     = 1'b0;
        adj_waddr  = '0;
        adj_wdata  = '0;
        adj_raddr  = {cur_reg, idx_reg[SLW-1:0]};
        q_we       = 1'b0;
        q_waddr    = tail_reg[NVW-1:0];
        q_wdata    = adj_rdata;
        q_raddr    = head_reg[NVW-1:0];
        case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    case (in_op)
                        gbfs_pkg::OP_ADD:   state_next = S_AREAD;
                        gbfs_pkg::OP_CLEAR: state_next = S_EMIT;
                        gbfs_pkg::OP_BFS: begin
                            if (in_range(in_a)) begin
                                q_we       = 1'b1;
                                q_waddr    = '0;
                                q_wdata    = in_a;
                                state_next = S_QRD;
                            end else begin
                                state_next = S_EMIT;
                            end
                        end
                        default: state_next = S_IDLE;
                    endcase
                end
            end
            S_AREAD: state_next = S_ACHK;
            S_ACHK: begin
                if (w_ok) begin
                    adj_we     = 1'b1;
                    adj_waddr  = {a_reg[NVW-1:0], da_reg[SLW-1:0]};
                    adj_wdata  = b_reg;
                    state_next = S_AWR2;
                end else begin
                    state_next = S_EMIT;
                end
            end
            S_AWR2: begin
                // For a self-loop the second entry lands one slot further on.
                adj_we     = 1'b1;
                adj_waddr  = {b_reg[NVW-1:0], (a_reg == b_reg) ?
                              SLW'(da_reg + DGW'(1)) : db_reg[SLW-1:0]};
                adj_wdata  = a_reg;
                state_next = S_EMIT;
            end
            S_EMIT: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            S_QRD:  state_next = S_QGOT;
            S_QGOT: begin
                if (deg_q == '0) begin
                    state_next = S_VWAIT;
                end else begin
                    state_next = S_LRD;
                end
            end
            S_VWAIT: begin
                if (res_ready) begin
                    if (out_reg.last) begin
                        state_next = S_IDLE;
                    end else begin
                        state_next = S_QRD;
                    end
                end
            end
            S_LRD: state_next = S_LGOT;
            S_LGOT: begin
                if (fresh) begin
                    q_we = 1'b1;
                end
                if (idx_reg < cdeg_reg) begin
                    state_next = S_LRD;
                end else begin
                    state_next = S_VWAIT;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // A vertex is reported only after its list is scanned, so the report is the last
    // one exactly when the queue is empty at that point.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            degv_reg  <= '0;
            vis_reg   <= '0;
        end else begin
            state_reg <= state_next;
            case (state_reg)
                S_IDLE: begin
                    a_reg <= in_a;
                    b_reg <= in_b;
                    if (in_valid && in_op == gbfs_pkg::OP_CLEAR) begin
                        degv_reg <= '0;
                        out_reg  <= '{gbfs_pkg::KIND_ACK, '0, 1'b0, 1'b1};
                    end
                    if (in_valid && in_op == gbfs_pkg::OP_BFS) begin
                        out_reg  <= '{gbfs_pkg::KIND_REPORT, in_a, 1'b1, 1'b1};
                        vis_reg  <= in_range(in_a) ? (NV'(1) << in_a[NVW-1:0]) : '0;
                        head_reg <= '0;
                        tail_reg <= QCW'(1);
                    end
                end
                S_AREAD: begin
                    da_reg <= deg_a;
                    db_reg <= deg_b;
                end
                S_ACHK: begin
                    out_reg <= '{gbfs_pkg::KIND_ACK, '0, !w_ok, 1'b1};
                    if (w_ok) begin
                        deg_reg[a_reg[NVW-1:0]]  <= (a_reg == b_reg) ?
                                                    DGW'(da_reg + DGW'(2)) :
                                                    DGW'(da_reg + DGW'(1));
                        degv_reg[a_reg[NVW-1:0]] <= 1'b1;
                    end
                end
                S_AWR2: begin
                    if (a_reg != b_reg) begin
                        deg_reg[b_reg[NVW-1:0]]  <= DGW'(db_reg + DGW'(1));
                        degv_reg[b_reg[NVW-1:0]] <= 1'b1;
                    end
                end
                S_QRD: begin
                    head_reg <= QCW'(head_reg + QCW'(1));
                end
                S_QGOT: begin
                    cur_reg  <= q_rdata[NVW-1:0];
                    idx_reg  <= '0;
                    cdeg_reg <= deg_q;
                    // Used as is when the vertex has an empty list.
                    out_reg  <= '{gbfs_pkg::KIND_REPORT, q_rdata, 1'b0,
                                  (head_reg == tail_reg)};
                end
                S_LRD: begin
                    idx_reg <= DGW'(idx_reg + DGW'(1));
                end
                S_LGOT: begin
                    if (fresh) begin
                        vis_reg[adj_rdata[NVW-1:0]] <= 1'b1;
                        tail_reg <= QCW'(tail_reg + QCW'(1));
                    end
                    if (!(idx_reg < cdeg_reg)) begin
                        out_reg <= '{gbfs_pkg::KIND_REPORT, VW'(cur_reg), 1'b0,
                                     (head_reg == tail_reg) && !fresh};
                    end
                end
                default: ;
            endcase
        end
    end
endmodule

FILE: tb/sv/graph_bfs_engine_checker.sv
// Checker that predicts the engine's result words and compares them with the output channel.
`timescale 1ns / 100ps
module graph_bfs_engine_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,
    input  logic [1:0]  s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [7:0]  m_axis_tdata,
    input  logic        m_axis_tuser,
    input  logic        m_axis_tlast,
    output int          fail_count,
    output int          pending_count
);

    logic [4:0]        degree [gbfs_pkg::NUM_VERTICES];
    logic [4:0]        adj [gbfs_pkg::NUM_VERTICES][gbfs_pkg::MAX_DEGREE];
    gbfs_pkg::result_t pending_results[$];

    function automatic gbfs_pkg::result_t make_result(logic k, logic [4:0] v, logic st,
                                                      logic lst);
        gbfs_pkg::result_t r;
        r.kind = k;
        r.vertex = v;
        r.status = st;
        r.last = lst;
        return r;
    endfunction

    task automatic add_expected(gbfs_pkg::result_t r);
        pending_results = {pending_results, r};
    endtask

    task automatic link(int v, logic [4:0] w);
        adj[v][degree[v]] = w;
        degree[v] = degree[v] + 5'd1;
    endtask

    task automatic predict_word(logic [1:0] op, logic [4:0] a, logic [4:0] b);
        bit         ok;
        bit         seen [gbfs_pkg::NUM_VERTICES];
        logic [4:0] fifo [gbfs_pkg::NUM_VERTICES];
        int         head, tail, v;
        case (op)
            gbfs_pkg::OP_ADD: begin
                ok = 1;
                if (a >= gbfs_pkg::NUM_VERTICES || b >= gbfs_pkg::NUM_VERTICES) ok = 0;
                else if (a == b) begin
                    if (degree[a] + 2 > gbfs_pkg::MAX_DEGREE) ok = 0;
                end else begin
                    if (degree[a] + 1 > gbfs_pkg::MAX_DEGREE ||
                        degree[b] + 1 > gbfs_pkg::MAX_DEGREE) ok = 0;
                end
                if (ok) begin
                    link(a, b);
                    link(b, a);
                end
                add_expected(make_result(gbfs_pkg::KIND_ACK, 5'd0, !ok, 1'b1));
            end
            gbfs_pkg::OP_BFS: begin
                if (a >= gbfs_pkg::NUM_VERTICES) begin
                    add_expected(make_result(gbfs_pkg::KIND_REPORT, a, 1'b1, 1'b1));
                end else begin
                    foreach (seen[i]) seen[i] = 0;
                    head = 0;
                    tail = 1;
                    fifo[0] = a;
                    seen[a] = 1;
                    while (head < tail) begin
                        v = fifo[head];
                        head++;
                        add_expected(make_result(gbfs_pkg::KIND_REPORT, 5'(v), 1'b0, 1'b0));
                        for (int i = 0; i < degree[v]; i++) begin
                            if (!seen[adj[v][i]] && tail < gbfs_pkg::NUM_VERTICES) begin
                                seen[adj[v][i]] = 1;
                                fifo[tail] = adj[v][i];
                                tail++;
                            end
                        end
                    end
                    // The last flag goes on the final reported vertex.
                    pending_results[$].last = 1'b1;
                end
            end
            gbfs_pkg::OP_CLEAR: begin
                foreach (degree[i]) degree[i] = 5'd0;
                add_expected(make_result(gbfs_pkg::KIND_ACK, 5'd0, 1'b0, 1'b1));
            end
            default: ;
        endcase
    endtask

    always @(posedge aclk) begin
        gbfs_pkg::result_t want;
        int                errs;
        errs = 0;
        if (!aresetn) begin
            foreach (degree[i]) degree[i] = 5'd0;
            fail_count <= 0;
            pending_count <= 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                predict_word(s_axis_tuser, s_axis_tdata[4:0], s_axis_tdata[9:5]);
            if (m_axis_tvalid && m_axis_tready) begin
                if (pending_results.size() == 0) begin
                    $error("unexpected result word: tdata %h", m_axis_tdata);
                    errs++;
                end else begin
                    want = pending_results.pop_front();
                    if (want.kind !== m_axis_tuser) begin
                        $error("kind: expected %0d, actual %0d", want.kind, m_axis_tuser);
                        errs++;
                    end
                    if (want.vertex !== m_axis_tdata[4:0]) begin
                        $error("vertex: expected %0d, actual %0d", want.vertex,
                            m_axis_tdata[4:0]);
                        errs++;
                    end
                    if (want.status !== m_axis_tdata[5]) begin
                        $error("status: expected %0d, actual %0d", want.status,
                            m_axis_tdata[5]);
                        errs++;
                    end
                    if (want.last !== m_axis_tlast) begin
                        $error("last: expected %0d, actual %0d", want.last, m_axis_tlast);
                        errs++;
                    end
                end
            end
            fail_count <= fail_count + errs;
            pending_count <= pending_results.size();
        end
    end

endmodule

FILE: tb/sv/graph_bfs_engine_tb.sv
// Testbench top: drives graph commands into the engine and reports the verdict.
`timescale 1ns / 100ps
module graph_bfs_engine_tb;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = 0;
    logic [1:0]  s_axis_tuser = 0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [7:0]  m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;
    int          fail_count;
    int          pending_count;
    bit          stall_enable = 1;
    int          rx_wait = 0;

    always #10 aclk = ~aclk;

    graph_bfs_engine dut (.*);
    graph_bfs_engine_checker checker_i (.*);

    // Receiver: a drawn number of idle cycles before each word is taken.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 0;
            rx_wait = 0;
        end else if (m_axis_tready && m_axis_tvalid) begin
            rx_wait = stall_enable ? $urandom_range(0, 6) : 0;
            m_axis_tready <= (rx_wait == 0);
        end else if (!m_axis_tready) begin
            if (rx_wait > 0) rx_wait--;
            if (rx_wait == 0) m_axis_tready <= 1;
        end
    end

    task automatic send_word(logic [1:0] op, logic [4:0] a, logic [4:0] b);
        int gap;
        gap = stall_enable ? $urandom_range(0, 6) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tuser <= op;
        s_axis_tdata <= {6'b0, b, a};
        s_axis_tvalid <= 1;
        do @(posedge aclk); while (!s_axis_tready);
    endtask

    task automatic send_random_word(int span);
        int r;
        logic [4:0] a, b;
        r = $urandom_range(0, 99);
        a = (span == 0) ? 5'($urandom) : 5'($urandom_range(0, span));
        b = (span == 0) ? 5'($urandom) : 5'($urandom_range(0, span));
        if (r < 65) send_word(gbfs_pkg::OP_ADD, a, b);
        else if (r < 88) send_word(gbfs_pkg::OP_BFS, a, b);
        else if (r < 93) send_word(gbfs_pkg::OP_CLEAR, a, b);
        else send_word(gbfs_pkg::OP_RSVD, a, b);
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        // Directed: empty graph, extremes, self-loops, full list, bad opcode.
        send_word(gbfs_pkg::OP_BFS, 0, 0);
        send_word(gbfs_pkg::OP_BFS, 31, 31);
        send_word(gbfs_pkg::OP_ADD, 0, 31);
        send_word(gbfs_pkg::OP_ADD, 31, 31);
        send_word(gbfs_pkg::OP_ADD, 5, 5);
        send_word(gbfs_pkg::OP_BFS, 31, 0);
        send_word(gbfs_pkg::OP_RSVD, 31, 31);
        for (int i = 1; i <= 16; i++) send_word(gbfs_pkg::OP_ADD, 7, 5'(i + 8));
        send_word(gbfs_pkg::OP_ADD, 7, 3);
        send_word(gbfs_pkg::OP_BFS, 7, 0);
        send_word(gbfs_pkg::OP_CLEAR, 31, 31);
        send_word(gbfs_pkg::OP_BFS, 7, 0);
        // Random phases: dense small graphs alternating with the full vertex range.
        for (int p = 0; p < 8; p++) begin
            stall_enable = (p % 3 != 2);
            for (int i = 0; i < 48; i++) send_random_word(p % 2 ? 0 : 9);
        end
        s_axis_tvalid <= 0;
        stall_enable = 1;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (fail_count == 0 && pending_count == 0) $display("graph_bfs_engine: match");
        else $display("graph_bfs_engine: mismatch");
        $finish;
    end

    initial begin
        #20ms;
        $display("graph_bfs_engine: mismatch");
        $finish;
    end

endmodule
